// File: rtl/csv_record_tokenizer_top_macros.svh
// assertion macros used by the bound checker csvt_checker
`ifndef CSV_RECORD_TOKENIZER_TOP_MACROS_SVH
`define CSV_RECORD_TOKENIZER_TOP_MACROS_SVH

// same-cycle implication
`define CSVT_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("csv tokenizer check failed");

// next-cycle implication
`define CSVT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("csv tokenizer check failed");

`endif

// File: rtl/csvt_pkg.sv
`timescale 1ns / 1ps

package csvt_pkg;

   localparam logic [7:0] CH_LF = 8'd10;
   localparam logic [7:0] CH_CR = 8'd13;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int MAX_TOKENS  = 3;

   typedef enum logic [1:0] {
      KIND_BYTE       = 2'd0,
      KIND_FIELD_END  = 2'd1,
      KIND_RECORD_END = 2'd2,
      KIND_TABLE_END  = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CFG_SEPARATOR     = 3'd0,
      CFG_QUOTE         = 3'd1,
      CFG_QUOTE_ENABLE  = 3'd2,
      CFG_ESCAPE_FIRST  = 3'd3,
      CFG_ESCAPE_SECOND = 3'd4,
      CFG_ESCAPE_ENABLE = 3'd5
   } cfg_index_type;

   typedef struct packed {
      logic [7:0] separator_byte;
      logic [7:0] quote_byte;
      logic       quote_enable;
      logic [7:0] escape_first;
      logic [7:0] escape_second;
      logic       escape_enable;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      separator_byte: 8'd44,
      quote_byte:     8'd34,
      quote_enable:   1'b1,
      escape_first:   8'd34,
      escape_second:  8'd34,
      escape_enable:  1'b1
   };

   typedef struct packed {
      logic within_quotes;
      logic line_has_content;
      logic in_newline_run;
      logic escape_pending;
      logic table_done;
   } parse_state_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } token_type;

   typedef struct packed {
      logic [1:0]                 cnt;
      token_type [MAX_TOKENS-1:0] toks;
   } entry_type;

   typedef struct packed {
      logic not_full;
      logic not_empty;
   } queue_status_type;

   typedef struct packed {
      parse_state_type st;
      logic            emit;
      token_type       tok;
   } body_res_type;

   typedef struct packed {
      parse_state_type st;
      entry_type       ent;
   } step_res_type;

   function automatic logic is_newline(logic [7:0] b);
      return (b == CH_LF) || (b == CH_CR);
   endfunction

   function automatic step_res_type add_tok(step_res_type r, token_type t);
      step_res_type o;
      o = r;
      if (r.ent.cnt != 2'd3) begin
         o.ent.toks[r.ent.cnt] = t;
         o.ent.cnt = r.ent.cnt + 2'd1;
      end
      return o;
   endfunction

   // quote, newline and plain byte
   function automatic body_res_type body_fn(parse_state_type s, cfg_type c, logic [7:0] b);
      body_res_type r;
      r.st = s;
      r.emit = 1'b0;
      r.tok = '{kind: KIND_BYTE, data: 8'd0};
      if (c.quote_enable && (b == c.quote_byte)) begin
         r.st.within_quotes = !s.within_quotes;
         r.st.line_has_content = 1'b1;
      end else if (!s.within_quotes && is_newline(b)) begin
         r.emit = 1'b1;
         if (s.line_has_content) begin
            r.tok.kind = KIND_RECORD_END;
            r.st.line_has_content = 1'b0;
            r.st.within_quotes = 1'b0;
            r.st.in_newline_run = 1'b1;
         end else begin
            r.tok.kind = KIND_TABLE_END;
            r.st.table_done = 1'b1;
         end
      end else begin
         r.emit = 1'b1;
         r.tok = '{kind: KIND_BYTE, data: b};
         r.st.line_has_content = 1'b1;
      end
      return r;
   endfunction

   function automatic step_res_type step_fn(parse_state_type s, cfg_type c, logic at_end,
                                            logic [7:0] b);
      step_res_type r;
      body_res_type br;
      logic consumed;
      logic skip;
      r.st = s;
      r.ent = '0;
      consumed = 1'b0;
      skip = 1'b0;
      if (!s.table_done) begin
         if (s.escape_pending) begin
            r.st.escape_pending = 1'b0;
            if (!at_end && (b == c.escape_second)) begin
               r = add_tok(r, '{kind: KIND_BYTE, data: c.quote_byte});
               r.st.line_has_content = 1'b1;
               consumed = 1'b1;
            end else begin
               br = body_fn(r.st, c, c.escape_first);
               r.st = br.st;
               if (br.emit) begin
                  r = add_tok(r, br.tok);
               end
            end
         end
         if (!consumed && !r.st.table_done) begin
            if (at_end) begin
               if (r.st.line_has_content) begin
                  r = add_tok(r, '{kind: KIND_RECORD_END, data: 8'd0});
               end
               r = add_tok(r, '{kind: KIND_TABLE_END, data: 8'd0});
               r.st.line_has_content = 1'b0;
               r.st.within_quotes = 1'b0;
               r.st.in_newline_run = 1'b0;
               r.st.table_done = 1'b1;
            end else begin
               if (r.st.in_newline_run) begin
                  if (is_newline(b)) begin
                     skip = 1'b1;
                  end else begin
                     r.st.in_newline_run = 1'b0;
                  end
               end
               if (!skip) begin
                  if (!r.st.within_quotes && (b == c.separator_byte)) begin
                     r = add_tok(r, '{kind: KIND_FIELD_END, data: 8'd0});
                     r.st.line_has_content = 1'b1;
                  end else if (c.quote_enable && c.escape_enable && (b == c.escape_first)) begin
                     r.st.escape_pending = 1'b1;
                  end else begin
                     br = body_fn(r.st, c, b);
                     r.st = br.st;
                     if (br.emit) begin
                        r = add_tok(r, br.tok);
                     end
                  end
               end
            end
         end
      end
      return r;
   endfunction

endpackage

// File: rtl/csvt_if.sv
`timescale 1ns / 1ps

interface csvt_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] in_byte;
   modport source (output valid, output req_type, output in_byte, input ready);
   modport sink (input valid, input req_type, input in_byte, output ready);
endinterface

interface csvt_rsp_if;
   logic                valid;
   logic                ready;
   csvt_pkg::kind_type  token_kind;
   logic [7:0]          out_byte;
   logic                last_of_run;
   modport source (output valid, output token_kind, output out_byte, output last_of_run,
                   input ready);
   modport sink (input valid, input token_kind, input out_byte, input last_of_run,
                 output ready);
endinterface

interface csvt_csr_if;
   logic                             valid;
   logic                             ready;
   logic [csvt_pkg::CSR_INDEX_W-1:0] index;
   logic [csvt_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/csv_record_tokenizer_top.sv
// path: an item is tokenized combinationally as it is accepted, and its results, if any, are
// written into a four-entry queue as one entry; the back end loads them one at a time into
// the output register. throughput: one item per cycle at the input while the queue is not
// full; results leave one per cycle while the receiver is ready. reset: synchronous, clears
// the parse flags, the queue and the output valid, and restores the default configuration
`timescale 1ns / 1ps

module csv_record_tokenizer_top (
   input  logic       clock,
   input  logic       reset,
   csvt_req_if.sink   req_ch,
   csvt_rsp_if.source rsp_ch,
   csvt_csr_if.sink   csr_ch
);

   csvt_pkg::queue_status_type q_status;
   csvt_pkg::entry_type        push_entry;
   csvt_pkg::entry_type        head_entry;
   logic                       push;
   logic                       pop;

   csvt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   csvt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   csvt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

// File: rtl/csvt_front.sv
`timescale 1ns / 1ps

module csvt_front (
   input  logic                       clock,
   input  logic                       reset,
   csvt_req_if.sink                   req_ch,
   csvt_csr_if.sink                   csr_ch,
   input  csvt_pkg::queue_status_type q_status,
   output logic                       push,
   output csvt_pkg::entry_type        push_entry
);

   csvt_pkg::cfg_type         cfg_ff, cfg_in;
   csvt_pkg::parse_state_type st_ff, st_in;
   csvt_pkg::step_res_type    res;
   logic                      accept;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = q_status.not_full;
   assign accept = req_ch.valid && q_status.not_full;

   assign res = csvt_pkg::step_fn(st_ff, cfg_ff, req_ch.req_type, req_ch.in_byte);

   assign push = accept && (res.ent.cnt != 2'd0);
   assign push_entry = res.ent;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csvt_pkg::cfg_index_type'(csr_ch.index))
            csvt_pkg::CFG_SEPARATOR:     cfg_in.separator_byte = csr_ch.data;
            csvt_pkg::CFG_QUOTE:         cfg_in.quote_byte = csr_ch.data;
            csvt_pkg::CFG_QUOTE_ENABLE:  cfg_in.quote_enable = csr_ch.data[0];
            csvt_pkg::CFG_ESCAPE_FIRST:  cfg_in.escape_first = csr_ch.data;
            csvt_pkg::CFG_ESCAPE_SECOND: cfg_in.escape_second = csr_ch.data;
            csvt_pkg::CFG_ESCAPE_ENABLE: cfg_in.escape_enable = csr_ch.data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   assign st_in = accept ? res.st : st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= csvt_pkg::CFG_RESET;
         st_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
         st_ff <= st_in;
      end
   end

endmodule

// File: rtl/csvt_queue.sv
`timescale 1ns / 1ps

module csvt_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  csvt_pkg::entry_type        push_entry,
   input  logic                       pop,
   output csvt_pkg::entry_type        head_entry,
   output csvt_pkg::queue_status_type q_status
);

   csvt_pkg::entry_type                  mem_ff [csvt_pkg::QUEUE_DEPTH];
   logic [csvt_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [csvt_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [csvt_pkg::QUEUE_PTR_W:0]       count_ff, count_in;

   assign q_status.not_full  = (count_ff != (csvt_pkg::QUEUE_PTR_W + 1)'(csvt_pkg::QUEUE_DEPTH));
   assign q_status.not_empty = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/csvt_back.sv
`timescale 1ns / 1ps

module csvt_back (
   input  logic                       clock,
   input  logic                       reset,
   input  csvt_pkg::entry_type        head_entry,
   input  csvt_pkg::queue_status_type q_status,
   output logic                       pop,
   csvt_rsp_if.source                 rsp_ch
);

   logic [1:0]          sub_ff, sub_in;
   logic                valid_ff, valid_in;
   csvt_pkg::token_type tok_ff, tok_in;
   logic                last_ff, last_in;
   logic                load;
   logic                is_last;

   assign load = q_status.not_empty && (!valid_ff || rsp_ch.ready);
   assign is_last = (sub_ff == (head_entry.cnt - 2'd1));
   assign pop = load && is_last;

   always_comb begin
      sub_in = sub_ff;
      valid_in = valid_ff;
      tok_in = tok_ff;
      last_in = last_ff;
      if (load) begin
         valid_in = 1'b1;
         tok_in = head_entry.toks[sub_ff];
         last_in = is_last;
         sub_in = is_last ? 2'd0 : sub_ff + 2'd1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
      last_ff <= last_in;
   end

   assign rsp_ch.valid = valid_ff;
   assign rsp_ch.token_kind = tok_ff.kind;
   assign rsp_ch.out_byte = tok_ff.data;
   assign rsp_ch.last_of_run = last_ff;

endmodule

// File: rtl/csvt_checker.sv
`timescale 1ns / 1ps
`include "csv_record_tokenizer_top_macros.svh"

module csvt_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] token_kind,
   input logic [7:0] out_byte,
   input logic       last_of_run
);

   logic        table_end;
   logic        stall;
   logic [10:0] rsp_word;

   assign table_end = rsp_valid && (token_kind == csvt_pkg::KIND_TABLE_END);
   assign stall = rsp_valid && !rsp_ready;
   assign rsp_word = {token_kind, out_byte, last_of_run};

   // stalled item holds
   `CSVT_ASSERT_NEXT(a_rsp_hold, stall, rsp_valid && $stable(rsp_word))

   // only field bytes carry data
   `CSVT_ASSERT_SAME(a_zero_data, rsp_valid && (token_kind != csvt_pkg::KIND_BYTE), out_byte == 8'd0)

   // table end closes the run
   `CSVT_ASSERT_SAME(a_table_end_last, table_end, last_of_run)

   // nothing follows a table end
   `CSVT_ASSERT_NEXT(a_quiet_after_end, table_end && rsp_ready, !rsp_valid)

endmodule

bind csv_record_tokenizer_top csvt_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .token_kind  (rsp_ch.token_kind),
   .out_byte    (rsp_ch.out_byte),
   .last_of_run (rsp_ch.last_of_run)
);

// File: sim/csv_record_tokenizer_checker.sv
`timescale 1ns / 1ps

module csv_record_tokenizer_checker (
   input  logic clock,
   input  logic reset,
   csvt_req_if  req_ch,
   csvt_rsp_if  rsp_ch,
   csvt_csr_if  csr_ch,
   output int   fail_count,
   output int   token_count,
   output int   waiting_count,
   output logic quoted_now
);
   import csvt_pkg::*;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } token_rec_type;

   cfg_type         cfg;
   parse_state_type st;
   token_rec_type   item_tokens[$];
   token_rec_type   awaited_tokens[$];
   int              mismatches;
   int              checked;

   function automatic void emit_token(kind_type k, logic [7:0] d);
      token_rec_type t;
      t.kind = k;
      t.data = d;
      t.last = 1'b0;
      if (item_tokens.size() < MAX_TOKENS) item_tokens = {item_tokens, t};
   endfunction

   function automatic logic is_line_break(logic [7:0] b);
      return (b == CH_LF) || (b == CH_CR);
   endfunction

   // quote toggle, line break or plain field byte
   function automatic void take_body_byte(logic [7:0] b);
      if (cfg.quote_enable && (b == cfg.quote_byte)) begin
         st.within_quotes = !st.within_quotes;
         st.line_has_content = 1'b1;
      end else if (!st.within_quotes && is_line_break(b)) begin
         if (st.line_has_content) begin
            emit_token(KIND_RECORD_END, 8'd0);
            st.line_has_content = 1'b0;
            st.within_quotes = 1'b0;
            st.in_newline_run = 1'b1;
         end else begin
            emit_token(KIND_TABLE_END, 8'd0);
            st.table_done = 1'b1;
         end
      end else begin
         emit_token(KIND_BYTE, b);
         st.line_has_content = 1'b1;
      end
   endfunction

   function automatic void take_text_byte(logic [7:0] b);
      if (st.in_newline_run) begin
         if (is_line_break(b)) return;
         st.in_newline_run = 1'b0;
      end
      if (!st.within_quotes && (b == cfg.separator_byte)) begin
         emit_token(KIND_FIELD_END, 8'd0);
         st.line_has_content = 1'b1;
      end else if (cfg.quote_enable && cfg.escape_enable && (b == cfg.escape_first)) begin
         st.escape_pending = 1'b1;
      end else begin
         take_body_byte(b);
      end
   endfunction

   function automatic void tokenize_item(logic at_end, logic [7:0] b);
      logic          used;
      token_rec_type t;
      used = 1'b0;
      item_tokens.delete();
      if (!st.table_done) begin
         if (st.escape_pending) begin
            st.escape_pending = 1'b0;
            if (!at_end && (b == cfg.escape_second)) begin
               emit_token(KIND_BYTE, cfg.quote_byte);
               st.line_has_content = 1'b1;
               used = 1'b1;
            end else begin
               take_body_byte(cfg.escape_first);
            end
         end
         if (!used && !st.table_done) begin
            if (at_end) begin
               if (st.line_has_content) emit_token(KIND_RECORD_END, 8'd0);
               emit_token(KIND_TABLE_END, 8'd0);
               st.line_has_content = 1'b0;
               st.within_quotes = 1'b0;
               st.in_newline_run = 1'b0;
               st.table_done = 1'b1;
            end else begin
               take_text_byte(b);
            end
         end
      end
      foreach (item_tokens[k]) begin
         t = item_tokens[k];
         t.last = (k == item_tokens.size() - 1);
         awaited_tokens = {awaited_tokens, t};
      end
   endfunction

   always @(posedge clock) begin
      token_rec_type want;
      if (reset) begin
         cfg = CFG_RESET;
         st = '0;
         awaited_tokens.delete();
         mismatches = 0;
         checked = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            checked++;
            if (awaited_tokens.size() == 0) begin
               mismatches++;
               $display("%0t: token with none expected: kind %0d byte %02h last %0b",
                        $time, rsp_ch.token_kind, rsp_ch.out_byte, rsp_ch.last_of_run);
            end else begin
               want = awaited_tokens.pop_front();
               if (rsp_ch.token_kind !== want.kind || rsp_ch.out_byte !== want.data ||
                   rsp_ch.last_of_run !== want.last) begin
                  mismatches++;
                  $display("%0t: expected kind %0d byte %02h last %0b, %s",
                           $time, want.kind, want.data, want.last,
                           $sformatf("got kind %0d byte %02h last %0b",
                                     rsp_ch.token_kind, rsp_ch.out_byte,
                                     rsp_ch.last_of_run));
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (cfg_index_type'(csr_ch.index))
               CFG_SEPARATOR:     cfg.separator_byte = csr_ch.data;
               CFG_QUOTE:         cfg.quote_byte = csr_ch.data;
               CFG_QUOTE_ENABLE:  cfg.quote_enable = csr_ch.data[0];
               CFG_ESCAPE_FIRST:  cfg.escape_first = csr_ch.data;
               CFG_ESCAPE_SECOND: cfg.escape_second = csr_ch.data;
               CFG_ESCAPE_ENABLE: cfg.escape_enable = csr_ch.data[0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) tokenize_item(req_ch.req_type, req_ch.in_byte);
      end
      fail_count <= mismatches;
      token_count <= checked;
      waiting_count <= awaited_tokens.size();
      quoted_now <= st.within_quotes;
   end

endmodule

// File: sim/csv_record_tokenizer_top_test.sv
`timescale 1ns / 1ps

module csv_record_tokenizer_top_test;
   import csvt_pkg::*;

   localparam int IDLE_PCT        = 12;
   localparam int STALL_LIMIT     = 1000;
   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 30;

   localparam logic [7:0] OPENING_TEXT [23] = '{
      "a", 8'h00, 8'hFF, ",", 8'h22, 8'h22, 8'h22, "q", ",", CH_LF, 8'h22, ",",
      CH_CR, CH_LF, CH_CR, "b", 8'h22, CH_CR, 8'h22, CH_LF, ",", "c", 8'h22
   };

   logic    clock;
   logic    reset;
   logic    calm;
   logic    quoted_now;
   int      fail_count;
   int      token_count;
   int      waiting_count;
   int      items_sent;
   int      settings_count;
   int      quiet_cycles;
   cfg_type cfg_now;

   csvt_req_if req_ch ();
   csvt_rsp_if rsp_ch ();
   csvt_csr_if csr_ch ();

   csv_record_tokenizer_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   csv_record_tokenizer_checker token_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .fail_count    (fail_count),
      .token_count   (token_count),
      .waiting_count (waiting_count),
      .quoted_now    (quoted_now)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic at_end, input logic [7:0] b);
      while (!calm && ($urandom_range(0, 99) < IDLE_PCT)) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.req_type <= at_end;
      req_ch.in_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic write_reg(input cfg_index_type idx, input logic [7:0] v);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   task automatic apply_config(input cfg_type c);
      write_reg(CFG_SEPARATOR, c.separator_byte);
      write_reg(CFG_QUOTE, c.quote_byte);
      write_reg(CFG_QUOTE_ENABLE, {7'd0, c.quote_enable});
      write_reg(CFG_ESCAPE_FIRST, c.escape_first);
      write_reg(CFG_ESCAPE_SECOND, c.escape_second);
      write_reg(CFG_ESCAPE_ENABLE, {7'd0, c.escape_enable});
      csr_ch.valid <= 1'b0;
      cfg_now = c;
      settings_count++;
   endtask

   // drain: wait until nothing is awaited, then wait further for items that yield no token
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (waiting_count != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_letter();
      return 8'($urandom_range(97, 122));
   endfunction

   function automatic logic [7:0] pick_marker();
      case ($urandom_range(0, 7))
         0: return ",";
         1: return ";";
         2: return 8'h09;
         3: return 8'h22;
         4: return "'";
         5: return "\\";
         6: return ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return cfg_now.separator_byte;
         1: return cfg_now.quote_byte;
         2: return cfg_now.escape_first;
         3: return cfg_now.escape_second;
         4: return CH_CR;
         5: return CH_LF;
         6, 7: return pick_letter();
         default: return 8'($urandom);
      endcase
   endfunction

   // one line of fields, some quoted with escapes and embedded breaks
   task automatic send_record();
      int nfields;
      nfields = $urandom_range(1, 4);
      for (int f = 0; f < nfields; f++) begin
         if (f != 0) send_item(1'b0, cfg_now.separator_byte);
         if ($urandom_range(0, 2) == 0) begin
            send_item(1'b0, cfg_now.quote_byte);
            repeat ($urandom_range(0, 4)) begin
               case ($urandom_range(0, 5))
                  0: begin
                     send_item(1'b0, cfg_now.escape_first);
                     send_item(1'b0, cfg_now.escape_second);
                  end
                  1: send_item(1'b0, cfg_now.separator_byte);
                  2: send_item(1'b0, ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF);
                  default: send_item(1'b0, pick_letter());
               endcase
            end
            send_item(1'b0, cfg_now.quote_byte);
         end else begin
            repeat ($urandom_range(0, 3)) send_item(1'b0, pick_letter());
         end
      end
      if ($urandom_range(0, 1) != 0) send_item(1'b0, CH_CR);
      send_item(1'b0, CH_LF);
   endtask

   // leaves the line with content and no held escape before a register change
   task automatic send_closing_byte();
      logic [7:0] b;
      do b = 8'($urandom);
      while (b == CH_CR || b == CH_LF ||
             (cfg_now.quote_enable && cfg_now.escape_enable && b == cfg_now.escape_first));
      send_item(1'b0, b);
   endtask

   initial begin
      cfg_type c;
      int      phase_start;
      int      variant;
      req_ch.valid = 1'b0;
      req_ch.req_type = 1'b0;
      req_ch.in_byte = 8'd0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      rsp_ch.ready = 1'b0;
      calm = 1'b0;
      items_sent = 0;
      settings_count = 0;
      quiet_cycles = 0;
      cfg_now = CFG_RESET;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (OPENING_TEXT[i]) send_item(1'b0, OPENING_TEXT[i]);
      // escape held across a register change
      settle();
      c = CFG_RESET;
      c.escape_first = "y";
      c.escape_second = "x";
      apply_config(c);
      send_item(1'b0, "q");

      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0: c = '{8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0};
            1: c = '{8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b1};
            2: c = CFG_RESET;
            default: begin
               c.separator_byte = pick_marker();
               c.quote_byte = pick_marker();
               c.quote_enable = ($urandom_range(0, 3) != 0);
               c.escape_first = pick_marker();
               c.escape_second = pick_marker();
               c.escape_enable = ($urandom_range(0, 3) != 0);
            end
         endcase
         apply_config(c);
         calm = (p == 2);
         phase_start = items_sent;
         while (items_sent - phase_start < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 3) != 0) send_record();
            else send_item(1'b0, pick_byte());
         end
         calm = 1'b0;
         send_closing_byte();
      end

      // close the table: end marker after a held escape, end marker on an
      // empty line, or a line break released from a held escape
      settle();
      c = '{",", 8'h22, 1'b1, "\\", 8'h22, 1'b1};
      apply_config(c);
      if (quoted_now) send_item(1'b0, 8'h22);
      send_item(1'b0, "a");
      send_item(1'b0, CH_LF);
      variant = $urandom_range(0, 2);
      case (variant)
         0: begin
            send_item(1'b0, "b");
            send_item(1'b0, "\\");
            send_item(1'b1, 8'($urandom));
         end
         1: send_item(1'b1, 8'($urandom));
         default: begin
            send_item(1'b0, "\\");
            settle();
            c.escape_first = CH_CR;
            apply_config(c);
            send_item(1'b0, "z");
         end
      endcase
      // nothing may follow the table end
      repeat (6) send_item(1'($urandom_range(0, 1)), pick_byte());
      settle();
      repeat (4) @(posedge clock);

      $display("%0d items over %0d register settings, %0d tokens checked",
               items_sent, settings_count, token_count);
      $display("table closed by case %0d (0 held escape, 1 end marker, 2 empty line)", variant);
      if (fail_count == 0 && waiting_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/csvt_pkg.sv
rtl/csvt_if.sv
rtl/csvt_front.sv
rtl/csvt_queue.sv
rtl/csvt_back.sv
rtl/csv_record_tokenizer_top.sv
rtl/csvt_checker.sv
sim/csv_record_tokenizer_checker.sv
sim/csv_record_tokenizer_top_test.sv
